[src/i2cm_pkg.sv]
// i2cm_pkg: shared types and codes for the I2C master bit engine.
// Used by i2cm_core and i2c_master_bit_engine; depends on nothing.

package i2cm_pkg;

    // Item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_STOP_A   = 5'd3,
        PH_STOP_B   = 5'd4,
        PH_W_LOW    = 5'd5,
        PH_W_HIGH   = 5'd6,
        PH_W_GAP    = 5'd7,
        PH_ACK_HIGH = 5'd8,
        PH_ACK_POLL = 5'd9,
        PH_R_LOW    = 5'd10,
        PH_R_HIGH   = 5'd11,
        PH_RA_LOW   = 5'd12,
        PH_RA_HIGH  = 5'd13
    } phase_t;

    localparam int HALF_W = 13;

    // Reset values of the timing register and its one-third gap
    localparam logic [HALF_W-1:0] HALF_RESET = 13'd12;
    localparam logic [HALF_W-1:0] GAP_RESET  = 13'd4;

    // Reciprocal of 3 for 13-bit values: floor(x * 2731 / 8192) == x / 3
    localparam logic [11:0] THIRD_MUL   = 12'd2731;
    localparam int          THIRD_SHIFT = 13;

    // One result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       ack_timeout;
        logic [7:0] rx_byte;
    } result_t;

endpackage

[src/i2cm_core.sv]
// i2cm_core: bus sequencer state and its combinational next-state logic.
// Each accepted word updates the state; the matching result word is produced.
// Depends on i2cm_pkg.

module i2cm_core #(
    parameter int ACK_POLL_LIMIT = 250
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        operation,
    input  logic [1:0]                  command,
    input  logic [7:0]                  tx_byte,
    input  logic                        send_ack,
    input  logic                        sda_in,
    input  logic [i2cm_pkg::HALF_W-1:0] half_ticks,
    input  logic [i2cm_pkg::HALF_W-1:0] gap_ticks,
    output i2cm_pkg::result_t           result
);

    i2cm_pkg::phase_t            phase_reg, phase_next;
    logic [i2cm_pkg::HALF_W-1:0] dly_reg, dly_next;
    logic [3:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [7:0]                  poll_reg, poll_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;
    logic                        ackc_reg, ackc_next;
    i2cm_pkg::cmd_t              cmd_reg, cmd_next;
    logic                        done;
    logic                        tmo;
    logic                        wait_over;
    logic [3:0]                  bit_inc;
    logic [7:0]                  shift_sh;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cm_pkg::PH_IDLE;
            dly_reg   <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ackc_reg  <= 1'b0;
            cmd_reg   <= i2cm_pkg::CMD_START;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            dly_reg   <= dly_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ackc_reg  <= ackc_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign bit_inc  = bit_reg + 4'd1;
    assign shift_sh = {shift_reg[6:0], 1'b0};

    // Next state for one word: command while idle, or one tick
    always_comb
    begin
        phase_next = phase_reg;
        dly_next   = dly_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ackc_next  = ackc_reg;
        cmd_next   = cmd_reg;
        done       = 1'b0;
        tmo        = 1'b0;

        // a wait counts down to one; zero or one ends it
        wait_over  = (dly_reg <= i2cm_pkg::HALF_W'(1));

        if (operation == i2cm_pkg::OP_CMD)
        begin
            if (phase_reg == i2cm_pkg::PH_IDLE)
            begin
                cmd_next = i2cm_pkg::cmd_t'(command);
                dly_next = half_ticks;
                unique case (i2cm_pkg::cmd_t'(command))
                    i2cm_pkg::CMD_START:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_START_A;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_STOP_A;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shift_next = tx_byte;
                        bit_next   = '0;
                        scl_next   = 1'b0;
                        sda_next   = tx_byte[7];
                        phase_next = i2cm_pkg::PH_W_LOW;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        shift_next = '0;
                        bit_next   = '0;
                        ackc_next  = send_ack;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_R_LOW;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        else if (phase_reg == i2cm_pkg::PH_ACK_POLL)
        begin
            // ACK polling: one sample per tick
            if (!sda_in)
            begin
                scl_next   = 1'b0;
                phase_next = i2cm_pkg::PH_IDLE;
                done       = 1'b1;
            end
            else if (poll_reg > 8'(ACK_POLL_LIMIT))
            begin
                sda_next   = 1'b0;
                scl_next   = 1'b1;
                dly_next   = half_ticks;
                phase_next = i2cm_pkg::PH_STOP_A;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end
        else if (phase_reg != i2cm_pkg::PH_IDLE)
        begin
            if (!wait_over)
            begin
                dly_next = dly_reg - i2cm_pkg::HALF_W'(1);
            end
            else
            begin
                dly_next = '0;
                unique case (phase_reg)
                    i2cm_pkg::PH_START_A:
                    begin
                        sda_next   = 1'b0;
                        dly_next   = half_ticks;
                        phase_next = i2cm_pkg::PH_START_B;
                    end
                    i2cm_pkg::PH_START_B:
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    i2cm_pkg::PH_STOP_A:
                    begin
                        sda_next   = 1'b1;
                        dly_next   = half_ticks;
                        phase_next = i2cm_pkg::PH_STOP_B;
                    end
                    i2cm_pkg::PH_STOP_B:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                        tmo        = (cmd_reg == i2cm_pkg::CMD_WRITE);
                    end
                    i2cm_pkg::PH_W_LOW:
                    begin
                        scl_next   = 1'b1;
                        dly_next   = half_ticks;
                        phase_next = i2cm_pkg::PH_W_HIGH;
                    end
                    i2cm_pkg::PH_W_HIGH:
                    begin
                        scl_next   = 1'b0;
                        dly_next   = gap_ticks;
                        phase_next = i2cm_pkg::PH_W_GAP;
                    end
                    i2cm_pkg::PH_W_GAP:
                    begin
                        shift_next = shift_sh;
                        bit_next   = bit_inc;
                        dly_next   = half_ticks;
                        if (bit_inc < 4'd8)
                        begin
                            sda_next   = shift_sh[7];
                            phase_next = i2cm_pkg::PH_W_LOW;
                        end
                        else
                        begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            poll_next  = '0;
                            phase_next = i2cm_pkg::PH_ACK_HIGH;
                        end
                    end
                    i2cm_pkg::PH_ACK_HIGH:
                    begin
                        poll_next  = '0;
                        phase_next = i2cm_pkg::PH_ACK_POLL;
                    end
                    i2cm_pkg::PH_R_LOW:
                    begin
                        scl_next   = 1'b1;
                        dly_next   = half_ticks;
                        phase_next = i2cm_pkg::PH_R_HIGH;
                    end
                    i2cm_pkg::PH_R_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], sda_in};
                        scl_next   = 1'b0;
                        bit_next   = bit_inc;
                        dly_next   = half_ticks;
                        if (bit_inc < 4'd8)
                        begin
                            phase_next = i2cm_pkg::PH_R_LOW;
                        end
                        else
                        begin
                            sda_next   = !ackc_reg;
                            phase_next = i2cm_pkg::PH_RA_LOW;
                        end
                    end
                    i2cm_pkg::PH_RA_LOW:
                    begin
                        scl_next   = 1'b1;
                        dly_next   = half_ticks;
                        phase_next = i2cm_pkg::PH_RA_HIGH;
                    end
                    i2cm_pkg::PH_RA_HIGH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result word seen after this item
    always_comb
    begin
        result.scl_out     = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
        result.done_res    = done;
        result.ack_timeout = tmo;
        result.rx_byte     = (cmd_next == i2cm_pkg::CMD_WRITE) ? 8'd0 : shift_next;
    end

    // Checks
    a_poll_from_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_ACK_POLL) |->
            ($past(phase_reg) == i2cm_pkg::PH_ACK_POLL ||
             $past(phase_reg) == i2cm_pkg::PH_ACK_HIGH))
        else $error("ACK poll entered from unexpected phase");

    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_W_LOW || phase_reg == i2cm_pkg::PH_R_LOW) |->
            (bit_reg < 4'd8))
        else $error("bit index past last data bit");

    a_tmo_write: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tmo) |-> (cmd_reg == i2cm_pkg::CMD_WRITE && done))
        else $error("timeout flagged outside a write");

endmodule

[src/i2c_master_bit_engine.sv]
// i2c_master_bit_engine: top level with timing register, sequencer and output skid.
// Each item's result word goes to the output register, or to the skid under stall.
// Throughput: one item per cycle with the skid empty; one sequencer pass per item.
// Output register plus one skid entry; input stalls only while the skid holds a word.
// Reset (rst_n low, async): bus idle high, sequencer idle, half period 12 ticks.
// Depends on i2cm_pkg and i2cm_core.

module i2c_master_bit_engine #(
    parameter int ACK_POLL_LIMIT = 250
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [1:0]                  command,
    input  logic [7:0]                  tx_byte,
    input  logic                        send_ack,
    input  logic                        sda_in,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        scl_out,
    output logic                        sda_release,
    output logic                        busy_res,
    output logic                        done_res,
    output logic                        ack_timeout,
    output logic [7:0]                  rx_byte,
    // configuration
    input  logic                        cfg_we,
    input  logic [i2cm_pkg::HALF_W-1:0] cfg_wdata
);

    logic [i2cm_pkg::HALF_W-1:0] half_reg;
    logic [i2cm_pkg::HALF_W-1:0] gap_reg;
    logic [i2cm_pkg::HALF_W+12:0] third_prod;
    logic                        in_acc;
    logic                        out_take;
    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    i2cm_pkg::result_t           res;
    i2cm_pkg::result_t           out_reg;
    i2cm_pkg::result_t           skid_reg;

    // Timing register and its one-third gap, via reciprocal multiply
    assign third_prod = {13'd0, cfg_wdata} * {14'd0, i2cm_pkg::THIRD_MUL};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= i2cm_pkg::HALF_RESET;
            gap_reg  <= i2cm_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            half_reg <= cfg_wdata;
            gap_reg  <= third_prod[i2cm_pkg::THIRD_SHIFT +: i2cm_pkg::HALF_W];
        end
    end

    // Handshake
    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    i2cm_core #(
        .ACK_POLL_LIMIT (ACK_POLL_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_acc),
        .operation  (operation),
        .command    (command),
        .tx_byte    (tx_byte),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .half_ticks (half_reg),
        .gap_ticks  (gap_reg),
        .result     (res)
    );

    // Output register and skid: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_acc)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = out_reg.scl_out;
    assign sda_release = out_reg.sda_release;
    assign busy_res    = out_reg.busy_res;
    assign done_res    = out_reg.done_res;
    assign ack_timeout = out_reg.ack_timeout;
    assign rx_byte     = out_reg.rx_byte;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("word accepted under stall was not parked");

    a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ack_timeout) |->
            (out_reg.done_res && !out_reg.busy_res))
        else $error("timeout without finishing the command");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> !out_reg.busy_res)
        else $error("done reported while still busy");

endmodule

[sim/tb_i2c_master_bit_engine.sv]
// tb_i2c_master_bit_engine: self-checking testbench for the I2C master bit engine.
// Drives command and tick words, predicts every result word and checks it in order.
// Depends on i2cm_pkg and i2c_master_bit_engine.

module tb_i2c_master_bit_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int ACK_POLL_MAX = 250;
    localparam int MAX_REPORTS  = 10;

    // Short names for the directed table
    localparam logic          K_TICK  = i2cm_pkg::OP_TICK;
    localparam logic          K_CMD   = i2cm_pkg::OP_CMD;
    localparam i2cm_pkg::cmd_t C_START = i2cm_pkg::CMD_START;
    localparam i2cm_pkg::cmd_t C_STOP  = i2cm_pkg::CMD_STOP;
    localparam i2cm_pkg::cmd_t C_WRITE = i2cm_pkg::CMD_WRITE;
    localparam i2cm_pkg::cmd_t C_READ  = i2cm_pkg::CMD_READ;

    // One input word as the sender sees it
    typedef struct packed {
        logic           op;
        i2cm_pkg::cmd_t cmd;
        logic [7:0]     tx;
        logic           ack;
        logic           sda;
    } bus_word_t;

    // Directed row: the word, and a typed-in result where one is given
    typedef struct packed {
        bus_word_t         w;
        logic              lit;
        i2cm_pkg::result_t r;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        operation;
    logic [1:0]                  command;
    logic [7:0]                  tx_byte;
    logic                        send_ack;
    logic                        sda_in;
    logic                        out_valid;
    logic                        out_stall;
    logic                        scl_out;
    logic                        sda_release;
    logic                        busy_res;
    logic                        done_res;
    logic                        ack_timeout;
    logic [7:0]                  rx_byte;
    logic                        cfg_we;
    logic [i2cm_pkg::HALF_W-1:0] cfg_wdata;

    logic in_fire;
    logic out_fire;

    // Predicted engine state
    i2cm_pkg::phase_t            bus_phase;
    logic [i2cm_pkg::HALF_W-1:0] half_ticks;
    logic [i2cm_pkg::HALF_W-1:0] tick_left;
    logic [3:0]                  bit_cnt;
    logic [7:0]                  shreg;
    logic [7:0]                  poll_cnt;
    logic                        scl_lvl;
    logic                        sda_lvl;
    logic                        ack_sel;
    i2cm_pkg::cmd_t              last_cmd;

    i2cm_pkg::result_t bus_expect_q[$];
    int                err_cnt    = 0;
    int                words_sent = 0;
    int                words_seen = 0;
    int                calm_left  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    assign in_fire  = in_valid & ~in_stall;
    assign out_fire = out_valid & ~out_stall;

    i2c_master_bit_engine #(
        .ACK_POLL_LIMIT (ACK_POLL_MAX)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .command     (command),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_out     (scl_out),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .ack_timeout (ack_timeout),
        .rx_byte     (rx_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    function automatic dir_row_t dir_row(input logic op, input i2cm_pkg::cmd_t c,
                                         input logic [7:0] tx, input logic ack,
                                         input logic sda, input logic lit,
                                         input i2cm_pkg::result_t r);
        dir_row_t d;
        d.w.op  = op;
        d.w.cmd = c;
        d.w.tx  = tx;
        d.w.ack = ack;
        d.w.sda = sda;
        d.lit   = lit;
        d.r     = r;
        return d;
    endfunction

    // Directed words, run with a half period of one tick.
    // Typed-in results: {scl, sda, busy, done, timeout, rx}
    dir_row_t dir_tab [0:26] = '{
        // tick while idle: nothing moves
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b1, {5'b11000, 8'h00}),
        dir_row(K_CMD,  C_START, 8'h00, 1'b0, 1'b1, 1'b1, {5'b11100, 8'h00}),
        // command while busy is dropped and is not a tick
        dir_row(K_CMD,  C_STOP,  8'hFF, 1'b1, 1'b0, 1'b1, {5'b11100, 8'h00}),
        // command fields on a tick are ignored
        dir_row(K_TICK, C_READ,  8'hFF, 1'b1, 1'b1, 1'b1, {5'b10100, 8'h00}),
        dir_row(K_TICK, C_WRITE, 8'h55, 1'b0, 1'b0, 1'b1, {5'b00010, 8'h00}),
        // stop from idle with the clock low
        dir_row(K_CMD,  C_STOP,  8'hAA, 1'b1, 1'b1, 1'b1, {5'b10100, 8'h00}),
        dir_row(K_TICK, C_STOP,  8'h00, 1'b0, 1'b0, 1'b1, {5'b11100, 8'h00}),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b1, {5'b11010, 8'h00}),
        // read 0xA5 and answer with ACK
        dir_row(K_CMD,  C_READ,  8'h5A, 1'b1, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_STOP,  8'h00, 1'b1, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_READ,  8'hFF, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b1, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0),
        dir_row(K_TICK, C_START, 8'h00, 1'b0, 1'b0, 1'b0, '0)
    };

    // Load the wait counter with a full half period and move on
    function automatic void half_wait(input i2cm_pkg::phase_t nxt);
        tick_left = half_ticks;
        bus_phase = nxt;
    endfunction

    // Advance the predicted engine by one accepted word, return the bus levels after it
    function automatic i2cm_pkg::result_t advance_bus(input bus_word_t w);
        i2cm_pkg::result_t r;
        logic              done;
        logic              tmo;
        done = 1'b0;
        tmo  = 1'b0;
        if (w.op == i2cm_pkg::OP_CMD)
        begin
            if (bus_phase == i2cm_pkg::PH_IDLE)
            begin
                last_cmd = w.cmd;
                case (w.cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_START_A);
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        sda_lvl = 1'b0;
                        scl_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_STOP_A);
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shreg   = w.tx;
                        bit_cnt = '0;
                        scl_lvl = 1'b0;
                        sda_lvl = w.tx[7];
                        half_wait(i2cm_pkg::PH_W_LOW);
                    end
                    default:
                    begin
                        shreg   = '0;
                        bit_cnt = '0;
                        ack_sel = w.ack;
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_R_LOW);
                    end
                endcase
            end
        end
        else if (bus_phase == i2cm_pkg::PH_ACK_POLL)
        begin
            // every tick samples SDA until ACK or the poll limit
            if (w.sda == 1'b0)
            begin
                scl_lvl   = 1'b0;
                bus_phase = i2cm_pkg::PH_IDLE;
                done      = 1'b1;
            end
            else if (poll_cnt > ACK_POLL_MAX)
            begin
                sda_lvl = 1'b0;
                scl_lvl = 1'b1;
                half_wait(i2cm_pkg::PH_STOP_A);
            end
            else
                poll_cnt = poll_cnt + 1'b1;
        end
        else if (bus_phase != i2cm_pkg::PH_IDLE)
        begin
            if (tick_left > 1)
                tick_left = tick_left - 1'b1;
            else
            begin
                tick_left = '0;
                case (bus_phase)
                    i2cm_pkg::PH_START_A:
                    begin
                        sda_lvl = 1'b0;
                        half_wait(i2cm_pkg::PH_START_B);
                    end
                    i2cm_pkg::PH_START_B:
                    begin
                        scl_lvl   = 1'b0;
                        bus_phase = i2cm_pkg::PH_IDLE;
                        done      = 1'b1;
                    end
                    i2cm_pkg::PH_STOP_A:
                    begin
                        sda_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_STOP_B);
                    end
                    i2cm_pkg::PH_STOP_B:
                    begin
                        bus_phase = i2cm_pkg::PH_IDLE;
                        done      = 1'b1;
                        tmo       = (last_cmd == i2cm_pkg::CMD_WRITE);
                    end
                    i2cm_pkg::PH_W_LOW:
                    begin
                        scl_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_W_HIGH);
                    end
                    i2cm_pkg::PH_W_HIGH:
                    begin
                        // short low gap: a third of a half period
                        scl_lvl   = 1'b0;
                        tick_left = half_ticks / 3;
                        bus_phase = i2cm_pkg::PH_W_GAP;
                    end
                    i2cm_pkg::PH_W_GAP:
                    begin
                        shreg   = {shreg[6:0], 1'b0};
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt < 4'd8)
                        begin
                            sda_lvl = shreg[7];
                            half_wait(i2cm_pkg::PH_W_LOW);
                        end
                        else
                        begin
                            sda_lvl  = 1'b1;
                            scl_lvl  = 1'b1;
                            poll_cnt = '0;
                            half_wait(i2cm_pkg::PH_ACK_HIGH);
                        end
                    end
                    i2cm_pkg::PH_ACK_HIGH:
                    begin
                        poll_cnt  = '0;
                        bus_phase = i2cm_pkg::PH_ACK_POLL;
                    end
                    i2cm_pkg::PH_R_LOW:
                    begin
                        scl_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_R_HIGH);
                    end
                    i2cm_pkg::PH_R_HIGH:
                    begin
                        shreg   = {shreg[6:0], w.sda};
                        scl_lvl = 1'b0;
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt < 4'd8)
                            half_wait(i2cm_pkg::PH_R_LOW);
                        else
                        begin
                            sda_lvl = ~ack_sel;
                            half_wait(i2cm_pkg::PH_RA_LOW);
                        end
                    end
                    i2cm_pkg::PH_RA_LOW:
                    begin
                        scl_lvl = 1'b1;
                        half_wait(i2cm_pkg::PH_RA_HIGH);
                    end
                    i2cm_pkg::PH_RA_HIGH:
                    begin
                        scl_lvl   = 1'b0;
                        bus_phase = i2cm_pkg::PH_IDLE;
                        done      = 1'b1;
                    end
                    default:
                        bus_phase = i2cm_pkg::PH_IDLE;
                endcase
            end
        end
        r.scl_out     = scl_lvl;
        r.sda_release = sda_lvl;
        r.busy_res    = (bus_phase != i2cm_pkg::PH_IDLE);
        r.done_res    = done;
        r.ack_timeout = tmo;
        r.rx_byte     = (last_cmd == i2cm_pkg::CMD_WRITE) ? 8'h00 : shreg;
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word, wait for the handshake, record its expected result
    task automatic push_word(input bus_word_t w, input logic lit,
                             input i2cm_pkg::result_t lit_val);
        int                gap;
        i2cm_pkg::result_t r;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 49) == 0)
                calm_left = $urandom_range(50, 200);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= w.op;
        command   <= w.cmd;
        tx_byte   <= w.tx;
        send_ack  <= w.ack;
        sda_in    <= w.sda;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = advance_bus(w);
        bus_expect_q.push_back(lit ? lit_val : r);
        words_sent++;
    endtask

    // Drain all results, then write the half period register
    task automatic set_half(input logic [i2cm_pkg::HALF_W-1:0] v);
        in_valid <= 1'b0;
        while (bus_expect_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        half_ticks = v;
        @(posedge clk);
    endtask

    // Issue one command and tick it through to idle; no_ack holds SDA high while polling
    task automatic run_cmd(input i2cm_pkg::cmd_t c, input logic no_ack);
        bus_word_t w;
        int        pick;
        int        ack_at;
        int        polls;
        pick  = $urandom_range(0, 9);
        w.op  = i2cm_pkg::OP_CMD;
        w.cmd = c;
        w.tx  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : (pick == 2) ? 8'h80 :
                (pick == 3) ? 8'h01 : 8'($urandom);
        w.ack = 1'($urandom_range(0, 1));
        w.sda = 1'($urandom_range(0, 1));
        push_word(w, 1'b0, '0);

        // ACK after a few polls, right at the poll limit, or never
        pick = $urandom_range(0, 99);
        if (no_ack)
            ack_at = ACK_POLL_MAX + 10;
        else if (pick < 5)
            ack_at = $urandom_range(ACK_POLL_MAX - 2, ACK_POLL_MAX + 1);
        else
            ack_at = $urandom_range(0, 4);
        polls = 0;

        while (bus_phase != i2cm_pkg::PH_IDLE)
        begin
            w.op  = ($urandom_range(0, 99) < 3) ? i2cm_pkg::OP_CMD : i2cm_pkg::OP_TICK;
            w.cmd = i2cm_pkg::cmd_t'($urandom_range(0, 3));
            w.tx  = 8'($urandom);
            w.ack = 1'($urandom_range(0, 1));
            w.sda = 1'($urandom_range(0, 1));
            if (bus_phase == i2cm_pkg::PH_ACK_POLL && w.op == i2cm_pkg::OP_TICK)
            begin
                // SDA stays high until the slave answers
                w.sda = (polls < ack_at);
                polls++;
            end
            push_word(w, 1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_words
        i2cm_pkg::result_t got;
        i2cm_pkg::result_t want;
        if (rst_n && out_fire)
        begin
            got = {scl_out, sda_release, busy_res, done_res, ack_timeout, rx_byte};
            words_seen++;
            if (bus_expect_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("word %0d: unexpected: scl %b sda %b busy %b done %b tmo %b rx %h",
                             words_seen, got.scl_out, got.sda_release, got.busy_res,
                             got.done_res, got.ack_timeout, got.rx_byte);
            end
            else
            begin
                want = bus_expect_q.pop_front();
                if (got.scl_out !== want.scl_out || got.sda_release !== want.sda_release ||
                    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                    got.ack_timeout !== want.ack_timeout || got.rx_byte !== want.rx_byte)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("word %0d: exp scl %b sda %b busy %b done %b tmo %b rx %h",
                                 words_seen, want.scl_out, want.sda_release, want.busy_res,
                                 want.done_res, want.ack_timeout, want.rx_byte);
                        $display("word %0d: got scl %b sda %b busy %b done %b tmo %b rx %h",
                                 words_seen, got.scl_out, got.sda_release, got.busy_res,
                                 got.done_res, got.ack_timeout, got.rx_byte);
                    end
                end
            end
        end
    end

    // Receiver stall: runs without stall, some long, then stall stretches
    initial
    begin : rx_stall
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (in_fire === 1'b1 || out_fire === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin : stim
        logic [i2cm_pkg::HALF_W-1:0] halves [3];
        int                          targets [3];
        int                          k;
        int                          j;
        int                          base;
        int                          pick;
        logic                        force_tmo;
        i2cm_pkg::cmd_t              c;
        bus_word_t                   w;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = i2cm_pkg::OP_TICK;
        command   = i2cm_pkg::CMD_START;
        tx_byte   = '0;
        send_ack  = 1'b0;
        sda_in    = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;

        // predicted state after reset
        bus_phase  = i2cm_pkg::PH_IDLE;
        half_ticks = i2cm_pkg::HALF_RESET;
        tick_left  = '0;
        bit_cnt    = '0;
        shreg      = '0;
        poll_cnt   = '0;
        scl_lvl    = 1'b1;
        sda_lvl    = 1'b1;
        ack_sel    = 1'b0;
        last_cmd   = i2cm_pkg::CMD_START;

        halves  = '{13'd1, 13'd2, 13'd3};
        targets = '{120, 30, 30};
        halves[2] = 13'($urandom_range(3, 6));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the shortest half period
        set_half(13'd1);
        foreach (dir_tab[i])
            push_word(dir_tab[i].w, dir_tab[i].lit, dir_tab[i].r);

        // random command sequences at several half periods
        for (k = 0; k < 3; k++)
        begin
            set_half(halves[k]);
            base      = words_sent;
            force_tmo = (k == 0);
            while (words_sent - base < targets[k])
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // stray ticks on an idle bus
                    for (j = 0; j < $urandom_range(1, 3); j++)
                    begin
                        w.op  = i2cm_pkg::OP_TICK;
                        w.cmd = i2cm_pkg::cmd_t'($urandom_range(0, 3));
                        w.tx  = 8'($urandom);
                        w.ack = 1'($urandom_range(0, 1));
                        w.sda = 1'($urandom_range(0, 1));
                        push_word(w, 1'b0, '0);
                    end
                end
                c = (pick < 48) ? i2cm_pkg::CMD_WRITE : (pick < 75) ? i2cm_pkg::CMD_READ :
                    (pick < 88) ? i2cm_pkg::CMD_START : i2cm_pkg::CMD_STOP;
                run_cmd(c, force_tmo && c == i2cm_pkg::CMD_WRITE);
                if (c == i2cm_pkg::CMD_WRITE)
                    force_tmo = 1'b0;
            end
        end

        in_valid <= 1'b0;
        while (bus_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
